[sv/cnms_pkg.sv]
// ----------------------------------------------------------------------------
// cnms_pkg
// Shared types, constants and calendar helpers for the cron next-match search.
// ----------------------------------------------------------------------------
package cnms_pkg;

   localparam int unsigned SEARCH_LIMIT = 2108160;
   localparam int unsigned STEP_W       = 22;

   localparam logic [24:0] SECS_PER_YEAR      = 25'd31536000;
   localparam logic [24:0] SECS_PER_LEAP_YEAR = 25'd31622400;
   localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
   localparam logic [11:0] SECS_PER_HOUR      = 12'd3600;
   localparam logic [5:0]  SECS_PER_MINUTE    = 6'd60;

   localparam logic [2:0] CSR_MINUTE  = 3'd0;
   localparam logic [2:0] CSR_HOUR    = 3'd1;
   localparam logic [2:0] CSR_DAY     = 3'd2;
   localparam logic [2:0] CSR_MONTH   = 3'd3;
   localparam logic [2:0] CSR_WEEKDAY = 3'd4;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_YEAR,
      OP_MONTH,
      OP_DAY,
      OP_HOUR,
      OP_MINUTE,
      OP_BUMP,
      OP_SEARCH,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
      logic day_done;
      logic hour_done;
      logic minute_done;
      logic hit;
      logic at_limit;
   } status_type;

   // Days in a month, month given 1..12.
   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      begin
         case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // Weekday plus a small step, wrapped to 0..6.
   function automatic logic [2:0] weekday_add(input logic [2:0] wd, input logic [1:0] inc);
      logic [3:0] sum;
      begin
         sum = {1'b0, wd} + {2'b00, inc};
         return (sum >= 4'd7) ? 3'(sum - 4'd7) : sum[2:0];
      end
   endfunction

endpackage

[sv/cnms_ctrl.sv]
// ----------------------------------------------------------------------------
// cnms_ctrl
// Sequencer: conversion phases, search loop and result handshake.
// ----------------------------------------------------------------------------
module cnms_ctrl import cnms_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      S_IDLE, S_YEAR, S_MONTH, S_DAY, S_HOUR, S_MINUTE, S_BUMP, S_SEARCH, S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic                   valid_ff, valid_in;
   logic                   out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            cmd.op = OP_YEAR;
            if (status.year_done) state_in = S_MONTH;
         end
         S_MONTH: begin
            cmd.op = OP_MONTH;
            if (status.month_done) state_in = S_DAY;
         end
         S_DAY: begin
            cmd.op = OP_DAY;
            if (status.day_done) state_in = S_HOUR;
         end
         S_HOUR: begin
            cmd.op = OP_HOUR;
            if (status.hour_done) state_in = S_MINUTE;
         end
         S_MINUTE: begin
            cmd.op = OP_MINUTE;
            if (status.minute_done) state_in = S_BUMP;
         end
         S_BUMP: begin
            cmd.op = OP_BUMP;     state_in = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.op = OP_SEARCH;
            if (status.hit || status.at_limit) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.op   = OP_EMIT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

[sv/cnms_dp.sv]
// ----------------------------------------------------------------------------
// cnms_dp
// Datapath: mask registers, calendar walk, calendar fields and minute stepper.
// ----------------------------------------------------------------------------
module cnms_dp import cnms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_wdata,
   input  logic [34:0] start_seconds,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [35:0] next_seconds,
   output logic        found
);

   logic [59:0] minute_mask_ff;
   logic [23:0] hour_mask_ff;
   logic [30:0] day_mask_ff;
   logic [11:0] month_mask_ff;
   logic [6:0]  weekday_mask_ff;

   logic [34:0]       rest_ff;
   logic [36:0]       cand_ff;
   logic [5:0]        minute_ff;
   logic [4:0]        hour_ff;
   logic [4:0]        day_ff;
   logic [3:0]        month_ff;
   logic [12:0]       year_ff;
   logic [2:0]        weekday_ff;
   logic [1:0]        y4_ff;
   logic [6:0]        y100_ff;
   logic [8:0]        y400_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [35:0]       next_ff;
   logic              found_ff;

   logic        leap;
   logic [24:0] ylen_secs;
   logic [4:0]  mlen;
   logic [21:0] mlen_secs;
   logic        hit;
   logic        step_en;

   assign leap      = ((y4_ff == 2'd0) && (y100_ff != 7'd0)) || (y400_ff == 9'd0);
   assign ylen_secs = leap ? SECS_PER_LEAP_YEAR : SECS_PER_YEAR;
   assign mlen      = month_len(month_ff, leap);

   always_comb begin
      case (mlen)
         5'd28:   mlen_secs = 22'd2419200;
         5'd29:   mlen_secs = 22'd2505600;
         5'd30:   mlen_secs = 22'd2592000;
         default: mlen_secs = 22'd2678400;
      endcase
   end

   assign hit = minute_mask_ff[minute_ff] && hour_mask_ff[hour_ff]
             && day_mask_ff[day_ff - 5'd1] && month_mask_ff[month_ff - 4'd1]
             && weekday_mask_ff[weekday_ff];

   assign status.year_done   = (rest_ff < {10'd0, ylen_secs});
   assign status.month_done  = (rest_ff < {13'd0, mlen_secs});
   assign status.day_done    = (rest_ff < {18'd0, SECS_PER_DAY});
   assign status.hour_done   = (rest_ff < {23'd0, SECS_PER_HOUR});
   assign status.minute_done = (rest_ff < {29'd0, SECS_PER_MINUTE});
   assign status.hit         = hit;
   assign status.at_limit    = (steps_ff == STEP_W'(SEARCH_LIMIT));

   // One-minute advance: the first bump after conversion, then each failed test
   assign step_en = (cmd.op == OP_BUMP)
                 || ((cmd.op == OP_SEARCH) && !hit && !status.at_limit);

   assign next_seconds = next_ff;
   assign found        = found_ff;

   // Mask registers
   always_ff @(posedge clock) begin
      if (reset) begin
         minute_mask_ff  <= '1;
         hour_mask_ff    <= '1;
         day_mask_ff     <= '1;
         month_mask_ff   <= '1;
         weekday_mask_ff <= '1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MINUTE:  minute_mask_ff  <= csr_wdata;
            CSR_HOUR:    hour_mask_ff    <= csr_wdata[23:0];
            CSR_DAY:     day_mask_ff     <= csr_wdata[30:0];
            CSR_MONTH:   month_mask_ff   <= csr_wdata[11:0];
            CSR_WEEKDAY: weekday_mask_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Calendar and search datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff    <= '0;
         cand_ff    <= '0;
         minute_ff  <= '0;
         hour_ff    <= '0;
         day_ff     <= 5'd1;
         month_ff   <= 4'd1;
         year_ff    <= 13'd1970;
         weekday_ff <= 3'd4;
         y4_ff      <= 2'd2;
         y100_ff    <= 7'd70;
         y400_ff    <= 9'd370;
         steps_ff   <= '0;
         next_ff    <= '0;
         found_ff   <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               rest_ff    <= start_seconds;
               cand_ff    <= {2'd0, start_seconds};
               minute_ff  <= '0;
               hour_ff    <= '0;
               day_ff     <= 5'd1;
               month_ff   <= 4'd1;
               year_ff    <= 13'd1970;
               weekday_ff <= 3'd4;
               y4_ff      <= 2'd2;
               y100_ff    <= 7'd70;
               y400_ff    <= 9'd370;
            end
            OP_YEAR: begin
               if (!status.year_done) begin
                  rest_ff    <= rest_ff - {10'd0, ylen_secs};
                  year_ff    <= year_ff + 13'd1;
                  y4_ff      <= y4_ff + 2'd1;
                  y100_ff    <= (y100_ff == 7'd99)  ? 7'd0 : y100_ff + 7'd1;
                  y400_ff    <= (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
                  weekday_ff <= weekday_add(weekday_ff, leap ? 2'd2 : 2'd1);
               end
            end
            OP_MONTH: begin
               if (!status.month_done) begin
                  rest_ff    <= rest_ff - {13'd0, mlen_secs};
                  month_ff   <= month_ff + 4'd1;
                  // Month length minus 28 is its low two bits
                  weekday_ff <= weekday_add(weekday_ff, mlen[1:0]);
               end
            end
            OP_DAY: begin
               if (!status.day_done) begin
                  rest_ff    <= rest_ff - {18'd0, SECS_PER_DAY};
                  day_ff     <= day_ff + 5'd1;
                  weekday_ff <= weekday_add(weekday_ff, 2'd1);
               end
            end
            OP_HOUR: begin
               if (!status.hour_done) begin
                  rest_ff <= rest_ff - {23'd0, SECS_PER_HOUR};
                  hour_ff <= hour_ff + 5'd1;
               end
            end
            OP_MINUTE: begin
               if (!status.minute_done) begin
                  rest_ff   <= rest_ff - {29'd0, SECS_PER_MINUTE};
                  minute_ff <= minute_ff + 6'd1;
               end
            end
            OP_BUMP: begin
               // Drop the leftover seconds and move one minute on
               cand_ff  <= cand_ff - {31'd0, rest_ff[5:0]} + 37'd60;
               steps_ff <= '0;
            end
            OP_SEARCH: begin
               if (step_en) begin
                  steps_ff <= steps_ff + 1'b1;
                  cand_ff  <= cand_ff + 37'd60;
               end
            end
            OP_EMIT: begin
               next_ff  <= cand_ff[35:0];
               found_ff <= hit && !status.at_limit;
            end
            default: ;
         endcase

         if (step_en) begin
            if (minute_ff != 6'd59) begin
               minute_ff <= minute_ff + 6'd1;
            end else begin
               minute_ff <= '0;
               if (hour_ff != 5'd23) begin
                  hour_ff <= hour_ff + 5'd1;
               end else begin
                  hour_ff    <= '0;
                  weekday_ff <= (weekday_ff == 3'd6) ? 3'd0 : weekday_ff + 3'd1;
                  if (day_ff != mlen) begin
                     day_ff <= day_ff + 5'd1;
                  end else begin
                     day_ff <= 5'd1;
                     if (month_ff != 4'd12) begin
                        month_ff <= month_ff + 4'd1;
                     end else begin
                        month_ff <= 4'd1;
                        year_ff  <= year_ff + 13'd1;
                        y4_ff    <= y4_ff + 2'd1;
                        y100_ff  <= (y100_ff == 7'd99)  ? 7'd0 : y100_ff + 7'd1;
                        y400_ff  <= (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
                     end
                  end
               end
            end
         end
      end
   end

endmodule

[sv/cron_next_match_search.sv]
// ----------------------------------------------------------------------------
// cron_next_match_search
// Finds the next minute allowed by five cron-style masks after a start time.
// ----------------------------------------------------------------------------
// One item at a time. An accepted start time is turned into calendar fields by
// walking its seconds down from 1970: one year per cycle, then one month, one
// day, one hour and one minute per cycle, each walk ending when the remainder
// is too small. The leftover seconds are then dropped and the time moved one
// minute on, and the search tests one minute per cycle for up to 2108160
// minutes. The block is ready again as the result goes valid; a result still
// waiting on rsp_tready holds the next one back.
// Minute, hour, day, month and weekday must all match (day and weekday are
// ANDed). When the horizon runs out the result is the minute after the last
// one tested, with found low. The user must write masks through the csr port
// only while the block is idle; the block itself does not enforce this. A
// write to an unused index is dropped.
module cron_next_match_search import cnms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [34:0] start_seconds
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [35:0] next_seconds
   output logic        rsp_tuser,   // [0] found
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_wdata
);

   cmd_type     cmd;
   status_type  status;
   logic [35:0] next_seconds;

   cnms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cnms_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .start_seconds (req_tdata[34:0]),
      .cmd           (cmd),
      .status        (status),
      .next_seconds  (next_seconds),
      .found         (rsp_tuser)
   );

   // Pad the result to whole bytes
   assign rsp_tdata = {4'd0, next_seconds};

endmodule

[sv/cnms_checker.sv]
// ----------------------------------------------------------------------------
// cnms_checker
// Port-level checks for the cron next-match search, bound to the top level.
// ----------------------------------------------------------------------------
module cnms_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // Busy after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while a search is running");

   // Conversion runs through the walk states first, so no result right after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared right after accept");

   // Nothing pending out of reset
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind cron_next_match_search cnms_checker u_cnms_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/cron_next_match_search_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cron_next_match_search_tb
// Self-checking bench for the cron next-match search block.
// ----------------------------------------------------------------------------
// Start times are streamed in through a queue-fed driver. Every accepted item
// is run through a calendar-stepping predictor that uses the mask settings in
// force, and the expected (next minute, found) pair is queued. The monitor
// compares each result with the oldest expectation. Mask settings change
// between phases, only while the block is idle.
module cron_next_match_search_tb;
   import cnms_pkg::*;

   localparam longint unsigned RUN_LIMIT = 1_500_000_000;

   typedef struct {
      logic [35:0] next_seconds;
      logic        found;
   } match_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [34:0] start_seconds
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [35:0] next_seconds
   logic        rsp_tuser;   // [0] found
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [59:0] csr_wdata;

   // Mask copy used by the predictor.
   logic [59:0] minute_allow;
   logic [23:0] hour_allow;
   logic [30:0] day_allow;
   logic [11:0] month_allow;
   logic [6:0]  weekday_allow;

   logic [34:0] start_queue[$];
   match_type   match_queue[$];
   int          idle_pct;
   logic        req_taken;
   logic        failed;
   longint unsigned cycles;

   cron_next_match_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
      bit leap;
      leap = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
      case (m)
         2: return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   // Walk the calendar one minute at a time from the minute after start.
   function automatic match_type find_next_minute(logic [34:0] start);
      longint unsigned cand, days, sod, z, era, doe, yoe, yr, doy, mp;
      int unsigned mi, hr, dy, mo, wd, steps;
      match_type res;
      cand = (longint'(start) / 60) * 60 + 60;
      days = cand / 86400;
      sod  = cand % 86400;
      hr = 32'(sod / 3600);
      mi = 32'((sod % 3600) / 60);
      wd = 32'((days + 4) % 7);
      // Civil date from day count (days since 0000-03-01 eras of 400 years).
      z   = days + 719468;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yr  = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      dy  = 32'(doy - (153 * mp + 2) / 5 + 1);
      mo  = 32'((mp < 10) ? mp + 3 : mp - 9);
      if (mo <= 2) yr++;
      res.found = 1'b0;
      for (steps = 0; steps < SEARCH_LIMIT; steps++) begin
         if (minute_allow[mi] && hour_allow[hr] && day_allow[dy-1] &&
             month_allow[mo-1] && weekday_allow[wd]) begin
            res.found = 1'b1;
            break;
         end
         cand += 60;
         mi++;
         if (mi == 60) begin
            mi = 0;
            hr++;
            if (hr == 24) begin
               hr = 0;
               wd = (wd + 1) % 7;
               dy++;
               if (dy > days_in_month(mo, 32'(yr))) begin
                  dy = 1;
                  mo++;
                  if (mo > 12) begin
                     mo = 1;
                     yr++;
                  end
               end
            end
         end
      end
      res.next_seconds = cand[35:0];
      return res;
   endfunction

   // Driver: present a new item once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= idle_pct);
         if (!req_tvalid || req_taken) begin
            if (start_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_tdata  <= {5'b0, start_queue.pop_front()};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Predict on acceptance, check results, count cycles.
   always @(posedge clock) begin
      match_type want;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset) begin
         cycles <= cycles + 1;
         if (cycles > RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
         if (req_tvalid && req_tready)
            match_queue.insert(match_queue.size(), find_next_minute(req_tdata[34:0]));
         if (rsp_tvalid && rsp_tready) begin
            if (match_queue.size() == 0) begin
               $error("unexpected result next_seconds=%0d", rsp_tdata[35:0]);
               failed <= 1'b1;
            end else begin
               want = match_queue.pop_front();
               if (rsp_tdata[35:0] !== want.next_seconds) begin
                  $error("next_seconds expected %0d actual %0d",
                         want.next_seconds, rsp_tdata[35:0]);
                  failed <= 1'b1;
               end
               if (rsp_tuser !== want.found) begin
                  $error("found expected %0d actual %0d", want.found, rsp_tuser);
                  failed <= 1'b1;
               end
            end
         end
      end
   end

   // Append one start time to the pending items.
   task automatic queue_start(logic [34:0] value);
      start_queue.insert(start_queue.size(), value);
   endtask

   // Write one mask register at a falling edge; mirror it in the predictor.
   task automatic write_mask(logic [2:0] idx, logic [59:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MINUTE:  minute_allow  = value[59:0];
         CSR_HOUR:    hour_allow    = value[23:0];
         CSR_DAY:     day_allow     = value[30:0];
         CSR_MONTH:   month_allow   = value[11:0];
         CSR_WEEKDAY: weekday_allow = value[6:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until all items are sent and all results are back, then settle.
   task automatic drain;
      wait (start_queue.size() == 0 && !req_tvalid && match_queue.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [59:0] rand60();
      return 60'({$urandom, $urandom});
   endfunction

   initial begin
      int style;
      logic [59:0] m;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      req_taken  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_MINUTE;
      csr_wdata  = '0;
      failed     = 1'b0;
      cycles     = 0;
      idle_pct   = 35;
      minute_allow  = '1;
      hour_allow    = '1;
      day_allow     = '1;
      month_allow   = '1;
      weekday_allow = '1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset masks: epoch, minute boundaries, field extremes, leap days.
      queue_start(35'd0);
      queue_start(35'd59);
      queue_start(35'd60);
      queue_start('1);
      queue_start(35'd951782399);   // into 2000-02-29
      queue_start(35'd4107542399);  // 2100 has no Feb 29
      queue_start(35'd946684799);   // year rollover
      queue_start(35'd4107455999);  // 2100-02-27 end of day
      drain();

      // Empty minute mask: search runs to the horizon. Out-of-range index dropped.
      write_mask(CSR_MINUTE, '0);
      write_mask(3'd5, '0);
      write_mask(3'd7, '0);
      queue_start(35'd123456789);
      drain();

      // Only the last slot of minute, hour, day and month, any weekday; upper write bits must be dropped.
      write_mask(CSR_MINUTE, 60'h800_0000_0000_0000);
      write_mask(CSR_HOUR, 60'hFFF_FFFF_FF80_0000);
      write_mask(CSR_DAY, 60'hFFF_FFFF_C000_0000);
      write_mask(CSR_MONTH, 60'hFFF_FFFF_FFFF_F800);
      write_mask(CSR_WEEKDAY, '1);
      queue_start(35'd946684000);   // 1999-12-31 late evening
      queue_start(35'd4133894000);  // 2100-12-30 late evening
      drain();

      // Weekday limited to Saturday, everything else open.
      write_mask(CSR_MINUTE, '1);
      write_mask(CSR_HOUR, '1);
      write_mask(CSR_DAY, '1);
      write_mask(CSR_MONTH, '1);
      write_mask(CSR_WEEKDAY, 60'h40);
      queue_start(35'd0);
      queue_start('1);
      drain();

      // Random phases; one runs without any idling.
      for (int phase = 0; phase < 5; phase++) begin
         idle_pct = (phase == 2) ? 0 : 35;
         style = $urandom_range(3);
         m = rand60() | (60'd1 << $urandom_range(59));
         write_mask(CSR_MINUTE, m);
         m = rand60() | (60'd1 << $urandom_range(23));
         write_mask(CSR_HOUR, m);
         m = (style == 2) ? (rand60() | (60'd1 << $urandom_range(27))) : '1;
         write_mask(CSR_DAY, m);
         // Clear at most two months so the next hit stays within weeks.
         m = (style == 3) ? ~((60'd1 << $urandom_range(11)) | (60'd1 << $urandom_range(11)))
                          : '1;
         write_mask(CSR_MONTH, m);
         m = (style == 1) ? (rand60() | (60'd1 << $urandom_range(6))) : '1;
         write_mask(CSR_WEEKDAY, m);
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(3) == 0)
               queue_start(35'($urandom_range(200_000_000)));
            else
               queue_start(35'({$urandom, $urandom}));
         end
         drain();
      end

      if (!failed)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
